// File: src/pslf_pkg.sv
// Shared types, codes and constants of the presence and sleep lamp mode controller.
package pslf_pkg;

	localparam int unsigned ENERGY_BITS = 16;
	localparam int unsigned TIME_BITS   = 32;
	localparam int unsigned PCT_BITS    = 8;
	localparam int unsigned LEVEL_BITS  = 16;
	localparam int unsigned FTIME_BITS  = 20;
	localparam int unsigned RES_BITS    = 5;
	localparam int unsigned CFG_IDX_BITS  = 2;
	localparam int unsigned CFG_DATA_BITS = 16;

	typedef enum logic [2:0] {
		MODE_ABSENT = 3'd0,
		MODE_AWAKE  = 3'd1,
		MODE_RELAX  = 3'd2,
		MODE_LIGHT  = 3'd3,
		MODE_DEEP   = 3'd4,
		MODE_WAKE   = 3'd5
	} lamp_mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_AWAKE_TH = 2'd0,
		CFG_RELAX_TH = 2'd1,
		CFG_DEEP_TH  = 2'd2,
		CFG_LED_RES  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic load_in;
		logic calc;
		logic mul;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_sts_t;

endpackage

// File: src/pslf_if.sv
// Channel interfaces: sensor update words, fade command words and register writes.
interface pslf_sensor_if;
	import pslf_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   auto_mode;
	logic [PCT_BITS-1:0]    brightness_percent;
	logic                   movement;
	logic                   presence;
	logic [ENERGY_BITS-1:0] energy_level;
	logic [TIME_BITS-1:0]   now_ms;

	modport source (output valid, auto_mode, brightness_percent, movement, presence,
		energy_level, now_ms, input ready);
	modport sink (input valid, auto_mode, brightness_percent, movement, presence,
		energy_level, now_ms, output ready);
endinterface

interface pslf_fade_if;
	import pslf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [2:0]            mode_now;
	logic                  fade_start;
	logic                  fade_out;
	logic [LEVEL_BITS-1:0] fade_level;
	logic [FTIME_BITS-1:0] fade_time_ms;

	modport source (output valid, mode_now, fade_start, fade_out, fade_level, fade_time_ms,
		input ready);
	modport sink (input valid, mode_now, fade_start, fade_out, fade_level, fade_time_ms,
		output ready);
endinterface

interface pslf_cfg_if;
	import pslf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/presence_sleep_lamp_fsm_unit.sv
// Top level of the presence and sleep lamp mode controller.
//  channel  | role   | word
//  sensor   | sink   | auto_mode, brightness_percent, movement, presence, energy_level, now_ms
//  fade     | source | mode_now, fade_start, fade_out, fade_level, fade_time_ms
//  cfg      | sink   | index, data (always ready)
// Each sensor word passes accept, mode step with scale, percent multiply and divide by 100 in turn;
// the next word is taken only after the last of them. Both divides are reciprocal multiplies.
// The fade word sits in an output register; a new sensor word is taken while it waits.
// The level step holds while the previous fade word is not taken.
// Reset clears the mode to absent, the entry time to zero and the thresholds; resolution 8.
module presence_sleep_lamp_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	pslf_sensor_if.sink sensor,
	pslf_fade_if.source fade,
	pslf_cfg_if.sink    cfg
);
	import pslf_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;
	logic     in_ready;

	assign sensor.ready = in_ready;

	pslf_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sensor.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pslf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.sensor (sensor),
		.cfg    (cfg),
		.fade   (fade)
	);

endmodule

// File: src/pslf_ctl.sv
// Sequencer: accept a sensor word, then run the mode, scale and level steps.
module pslf_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pslf_pkg::dp_sts_t sts,
	output pslf_pkg::ctl_cmd_t cmd
);
	import pslf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DIV  = 4'b1000
	} ctl_state_t;

	ctl_state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				// hold until the output register is free
				if (!sts.out_full) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/pslf_dp.sv
// Datapath: registers, mode rules, timeouts and fade level arithmetic.
module pslf_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pslf_pkg::ctl_cmd_t cmd,
	output pslf_pkg::dp_sts_t  sts,
	pslf_sensor_if.sink        sensor,
	pslf_cfg_if.sink           cfg,
	pslf_fade_if.source        fade
);
	import pslf_pkg::*;

	localparam logic [TIME_BITS-1:0] TMO_AWAKE = TIME_BITS'(5 * 60 * 1000);
	localparam logic [TIME_BITS-1:0] TMO_RELAX = TIME_BITS'(15 * 60 * 1000);
	localparam logic [TIME_BITS-1:0] TMO_WAKE  = TIME_BITS'(20 * 60 * 1000);
	localparam logic [20:0] RECIP10  = 21'd1677722;   // ceil(2^24 / 10)
	localparam logic [23:0] RECIP100 = 24'd10737419;  // ceil(2^30 / 100)
	localparam logic [6:0]  PCT_MAX  = 7'd100;

	logic [ENERGY_BITS-1:0] awake_th_q, relax_th_q, deep_th_q;
	logic [RES_BITS-1:0]    led_res_q;
	lamp_mode_t             mode_q;
	logic [TIME_BITS-1:0]   entry_q;

	logic                   auto_q, mov_q, pres_q;
	logic [6:0]             pct_q;
	logic [ENERGY_BITS-1:0] energy_q;
	logic [TIME_BITS-1:0]   now_q;

	lamp_mode_t             mode_s1;
	logic                   changed_s1;
	logic [LEVEL_BITS-1:0]  fs_s1;
	logic [39:0]            p1_s1;
	logic [22:0]            p2_s2;

	logic                   out_valid_q;

	function automatic lamp_mode_t next_mode(input lamp_mode_t m, input logic mov,
		input logic pres, input logic [ENERGY_BITS-1:0] e, input logic tmo,
		input logic [ENERGY_BITS-1:0] t1, input logic [ENERGY_BITS-1:0] t2,
		input logic [ENERGY_BITS-1:0] t3);
		lamp_mode_t r;
		r = m;
		if (m != MODE_ABSENT && !pres && !mov) begin
			r = MODE_ABSENT;
		end else begin
			case (m)
				MODE_AWAKE: begin
					if (!mov && e <= t1 && tmo) r = MODE_RELAX;
				end
				MODE_RELAX: begin
					if (mov && e > t1) r = MODE_AWAKE;
					else if (e <= t2 && tmo) r = MODE_LIGHT;
				end
				MODE_LIGHT: begin
					if (mov && e > t2) r = MODE_RELAX;
					else if (e <= t3) r = MODE_DEEP;
				end
				MODE_DEEP: begin
					if (mov && e > t3) r = MODE_WAKE;
				end
				MODE_WAKE: begin
					if (mov && e > t1) r = MODE_AWAKE;
					else if (!mov && e <= t2 && tmo) r = MODE_RELAX;
				end
				default: begin
					if (pres && !mov) r = MODE_RELAX;
					else if (mov) r = MODE_AWAKE;
					else r = MODE_ABSENT;
				end
			endcase
		end
		return r;
	endfunction

	// mode step
	logic [TIME_BITS-1:0]  elapsed;
	logic                  tmo;
	lamp_mode_t            nxt;
	logic [4:0]            res;
	logic [LEVEL_BITS-1:0] fs;
	logic [18:0]           fs_k;

	always_comb begin
		elapsed = now_q - entry_q;
		case (mode_q)
			MODE_AWAKE: tmo = elapsed > TMO_AWAKE;
			MODE_RELAX: tmo = elapsed > TMO_RELAX;
			MODE_WAKE:  tmo = elapsed > TMO_WAKE;
			default:    tmo = 1'b0;
		endcase
		if (auto_q) begin
			nxt = next_mode(mode_q, mov_q, pres_q, energy_q, tmo,
				awake_th_q, relax_th_q, deep_th_q);
		end else begin
			nxt = MODE_ABSENT;
		end
		res  = (led_res_q > 5'd16) ? 5'd16 : led_res_q;
		fs   = LEVEL_BITS'((17'd1 << res) - 17'd1);
		case (nxt)
			MODE_RELAX: fs_k = {3'd0, fs} * 19'd7;
			MODE_LIGHT: fs_k = {3'd0, fs} * 19'd3;
			MODE_WAKE:  fs_k = {3'd0, fs} * 19'd5;
			default:    fs_k = {3'd0, fs};
		endcase
	end

	// scale and level steps
	logic [LEVEL_BITS-1:0] scale;
	logic [46:0]           p3;
	logic                  fout;
	logic [FTIME_BITS-1:0] ftime;

	always_comb begin
		scale = (mode_s1 == MODE_AWAKE) ? fs_s1 : p1_s1[39:24];
		p3    = {24'd0, p2_s2} * {23'd0, RECIP100};
		case (mode_s1)
			MODE_AWAKE: begin fout = 1'b0; ftime = FTIME_BITS'(1000); end
			MODE_RELAX: begin fout = 1'b0; ftime = FTIME_BITS'(2000); end
			MODE_LIGHT: begin fout = 1'b0; ftime = FTIME_BITS'(3000); end
			MODE_DEEP:  begin fout = 1'b1; ftime = FTIME_BITS'(5000); end
			MODE_WAKE:  begin fout = 1'b0; ftime = FTIME_BITS'(15 * 60 * 1000); end
			default:    begin fout = 1'b1; ftime = FTIME_BITS'(2000); end
		endcase
	end

	assign cfg.ready    = 1'b1;
	assign sts.out_full = out_valid_q && !fade.ready;
	assign fade.valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awake_th_q  <= '0;
			relax_th_q  <= '0;
			deep_th_q   <= '0;
			led_res_q   <= RES_BITS'(8);
			mode_q      <= MODE_ABSENT;
			entry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_AWAKE_TH: awake_th_q <= cfg.data[ENERGY_BITS-1:0];
					CFG_RELAX_TH: relax_th_q <= cfg.data[ENERGY_BITS-1:0];
					CFG_DEEP_TH:  deep_th_q  <= cfg.data[ENERGY_BITS-1:0];
					CFG_LED_RES:  led_res_q  <= cfg.data[RES_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.calc) begin
				mode_q <= nxt;
				if (!auto_q || nxt != mode_q) entry_q <= now_q;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (fade.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			auto_q   <= sensor.auto_mode;
			mov_q    <= sensor.movement;
			pres_q   <= sensor.presence;
			pct_q    <= (sensor.brightness_percent > PCT_BITS'(PCT_MAX)) ?
				PCT_MAX : sensor.brightness_percent[6:0];
			energy_q <= sensor.energy_level;
			now_q    <= sensor.now_ms;
		end
		if (cmd.calc) begin
			mode_s1    <= nxt;
			changed_s1 <= nxt != mode_q;
			fs_s1      <= fs;
			p1_s1      <= {21'd0, fs_k} * {19'd0, RECIP10};
		end
		if (cmd.mul) begin
			p2_s2 <= {16'd0, pct_q} * {7'd0, scale};
		end
		if (cmd.finish) begin
			fade.mode_now     <= mode_s1;
			fade.fade_start   <= changed_s1;
			fade.fade_out     <= changed_s1 && fout;
			fade.fade_level   <= (changed_s1 && !fout) ? p3[45:30] : '0;
			fade.fade_time_ms <= changed_s1 ? ftime : '0;
		end
	end

endmodule

// File: verif/tb.sv
// Self-checking bench for the lamp mode controller: directed walk of every mode, then random updates.
`timescale 1ns / 1ps

module tb;
	import pslf_pkg::*;

	localparam int unsigned AWAKE_HOLD_MS  = 5 * 60 * 1000;
	localparam int unsigned RELAX_HOLD_MS  = 15 * 60 * 1000;
	localparam int unsigned WAKE_HOLD_MS   = 20 * 60 * 1000;
	localparam int unsigned FADE_ABSENT_MS = 2000;
	localparam int unsigned FADE_AWAKE_MS  = 1000;
	localparam int unsigned FADE_RELAX_MS  = 2000;
	localparam int unsigned FADE_LIGHT_MS  = 3000;
	localparam int unsigned FADE_DEEP_MS   = 5000;
	localparam int unsigned FADE_WAKE_MS   = 15 * 60 * 1000;
	localparam int          NUM_SEGS       = 9;
	localparam int          ITEMS_PER_SEG  = 155;

	typedef struct packed {
		bit                   auto_mode;
		bit [PCT_BITS-1:0]    pct;
		bit                   movement;
		bit                   presence;
		bit [ENERGY_BITS-1:0] energy;
		bit [TIME_BITS-1:0]   now;
	} sensor_word_t;

	typedef struct packed {
		lamp_mode_t            mode;
		bit                    start;
		bit                    fout;
		bit [LEVEL_BITS-1:0]   level;
		bit [FTIME_BITS-1:0]   ftime;
	} fade_word_t;

	logic clk;
	logic arst_n;

	pslf_sensor_if sensor_ch ();
	pslf_fade_if   fade_ch ();
	pslf_cfg_if    cfg_ch ();

	presence_sleep_lamp_fsm_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sensor (sensor_ch),
		.fade   (fade_ch),
		.cfg    (cfg_ch)
	);

	sensor_word_t pending_words[$];
	fade_word_t   expected_fades[$];
	int           errors;
	int           idle_mode;
	int           sender_idle_pct [3] = '{38, 64, 0};
	int           stall_pct [3]       = '{64, 38, 0};

	lamp_mode_t           lamp_state;
	bit [TIME_BITS-1:0]   entry_ms;
	bit [ENERGY_BITS-1:0] th_awake, th_relax, th_deep;
	bit [RES_BITS-1:0]    led_res;

	bit [ENERGY_BITS-1:0] seg_th [3];
	bit [TIME_BITS-1:0]   gen_now;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit [TIME_BITS-1:0] hold_limit(lamp_mode_t m);
		case (m)
			MODE_AWAKE: return AWAKE_HOLD_MS;
			MODE_RELAX: return RELAX_HOLD_MS;
			MODE_WAKE:  return WAKE_HOLD_MS;
			default:    return '1;
		endcase
	endfunction

	function automatic lamp_mode_t next_lamp_mode(lamp_mode_t m, bit mov, bit pres,
		bit [ENERGY_BITS-1:0] e, bit tmo);
		if (m != MODE_ABSENT && !pres && !mov)
			return MODE_ABSENT;
		case (m)
			MODE_AWAKE: begin
				if (!mov && e <= th_awake && tmo)
					return MODE_RELAX;
				return MODE_AWAKE;
			end
			MODE_RELAX: begin
				if (mov && e > th_awake)
					return MODE_AWAKE;
				if (e <= th_relax && tmo)
					return MODE_LIGHT;
				return MODE_RELAX;
			end
			MODE_LIGHT: begin
				if (mov && e > th_relax)
					return MODE_RELAX;
				if (e <= th_deep)
					return MODE_DEEP;
				return MODE_LIGHT;
			end
			MODE_DEEP: begin
				if (mov && e > th_deep)
					return MODE_WAKE;
				return MODE_DEEP;
			end
			MODE_WAKE: begin
				if (mov && e > th_awake)
					return MODE_AWAKE;
				if (!mov && e <= th_relax && tmo)
					return MODE_RELAX;
				return MODE_WAKE;
			end
			default: begin
				if (pres && !mov)
					return MODE_RELAX;
				if (mov)
					return MODE_AWAKE;
				return MODE_ABSENT;
			end
		endcase
	endfunction

	function automatic fade_word_t step_lamp(sensor_word_t w);
		fade_word_t  f;
		lamp_mode_t  nxt;
		bit          tmo;
		int unsigned full, scale, pct;
		f.start = 1'b0;
		f.fout  = 1'b0;
		f.level = '0;
		f.ftime = '0;
		if (w.auto_mode) begin
			tmo = (w.now - entry_ms) > hold_limit(lamp_state);
			nxt = next_lamp_mode(lamp_state, w.movement, w.presence, w.energy, tmo);
		end else begin
			nxt = MODE_ABSENT;
			entry_ms = w.now;
		end
		if (nxt != lamp_state) begin
			full  = (led_res > 16) ? 32'hFFFF : (32'd1 << led_res) - 1;
			pct   = (w.pct > 100) ? 100 : w.pct;
			scale = 0;
			lamp_state = nxt;
			entry_ms   = w.now;
			f.start    = 1'b1;
			case (nxt)
				MODE_AWAKE: begin
					scale   = full;
					f.ftime = FTIME_BITS'(FADE_AWAKE_MS);
				end
				MODE_RELAX: begin
					scale   = full * 7 / 10;
					f.ftime = FTIME_BITS'(FADE_RELAX_MS);
				end
				MODE_LIGHT: begin
					scale   = full * 3 / 10;
					f.ftime = FTIME_BITS'(FADE_LIGHT_MS);
				end
				MODE_DEEP: begin
					f.fout  = 1'b1;
					f.ftime = FTIME_BITS'(FADE_DEEP_MS);
				end
				MODE_WAKE: begin
					scale   = full * 5 / 10;
					f.ftime = FTIME_BITS'(FADE_WAKE_MS);
				end
				default: begin
					f.fout  = 1'b1;
					f.ftime = FTIME_BITS'(FADE_ABSENT_MS);
				end
			endcase
			if (!f.fout)
				f.level = LEVEL_BITS'(pct * scale / 100);
		end
		f.mode = lamp_state;
		return f;
	endfunction

	function automatic void push_word(bit a, bit [PCT_BITS-1:0] p, bit mv, bit pr,
		bit [ENERGY_BITS-1:0] e, bit [TIME_BITS-1:0] t);
		sensor_word_t w;
		w.auto_mode = a;
		w.pct       = p;
		w.movement  = mv;
		w.presence  = pr;
		w.energy    = e;
		w.now       = t;
		pending_words.push_back(w);
	endfunction

	function automatic sensor_word_t random_word();
		sensor_word_t w;
		int unsigned  pick;
		pick = $urandom_range(99);
		if (pick < 2)
			gen_now = $urandom;
		else if (pick < 18)
			gen_now += $urandom_range(1300000, 250000);
		else
			gen_now += $urandom_range(2000, 0);
		w.now       = gen_now;
		w.auto_mode = chance(94);
		w.movement  = chance(35);
		w.presence  = chance(75);
		if ($urandom_range(9) == 0)
			w.pct = PCT_BITS'($urandom_range(255, 0));
		else
			w.pct = PCT_BITS'($urandom_range(110, 0));
		case ($urandom_range(7))
			0:       w.energy = '0;
			1:       w.energy = '1;
			2:       w.energy = ENERGY_BITS'($urandom);
			default: w.energy = seg_th[2'($urandom_range(2))] +
				ENERGY_BITS'($urandom_range(4)) - 16'd2;
		endcase
		return w;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_sensor
		sensor_word_t w;
		if (!arst_n) begin
			sensor_ch.valid <= 1'b0;
			lamp_state = MODE_ABSENT;
			entry_ms   = '0;
		end else begin
			if (sensor_ch.valid && sensor_ch.ready) begin
				w.auto_mode = sensor_ch.auto_mode;
				w.pct       = sensor_ch.brightness_percent;
				w.movement  = sensor_ch.movement;
				w.presence  = sensor_ch.presence;
				w.energy    = sensor_ch.energy_level;
				w.now       = sensor_ch.now_ms;
				expected_fades.push_back(step_lamp(w));
			end
			if (!sensor_ch.valid || sensor_ch.ready) begin
				if (pending_words.size() != 0 && !chance(sender_idle_pct[idle_mode])) begin
					w = pending_words.pop_front();
					sensor_ch.valid              <= 1'b1;
					sensor_ch.auto_mode          <= w.auto_mode;
					sensor_ch.brightness_percent <= w.pct;
					sensor_ch.movement           <= w.movement;
					sensor_ch.presence           <= w.presence;
					sensor_ch.energy_level       <= w.energy;
					sensor_ch.now_ms             <= w.now;
				end else begin
					sensor_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_fade
		fade_word_t f;
		if (!arst_n) begin
			fade_ch.ready <= 1'b0;
		end else begin
			if (fade_ch.valid && fade_ch.ready) begin
				if (expected_fades.size() == 0) begin
					$display("%0t unexpected fade word: mode_now %0d", $time, fade_ch.mode_now);
					errors++;
				end else begin
					f = expected_fades.pop_front();
					check_field("mode_now", f.mode, fade_ch.mode_now);
					check_field("fade_start", f.start, fade_ch.fade_start);
					check_field("fade_out", f.fout, fade_ch.fade_out);
					check_field("fade_level", f.level, fade_ch.fade_level);
					check_field("fade_time_ms", f.ftime, fade_ch.fade_time_ms);
				end
			end
			fade_ch.ready <= !chance(stall_pct[idle_mode]);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_awake = '0;
			th_relax = '0;
			th_deep  = '0;
			led_res  = 5'd8;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				CFG_AWAKE_TH: th_awake = cfg_ch.data;
				CFG_RELAX_TH: th_relax = cfg_ch.data;
				CFG_DEEP_TH:  th_deep  = cfg_ch.data;
				CFG_LED_RES:  led_res  = cfg_ch.data[RES_BITS-1:0];
				default: ;
			endcase
		end
	end

	task automatic write_reg(cfg_index_t idx, bit [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_config(bit [15:0] t1, bit [15:0] t2, bit [15:0] t3, bit [4:0] res);
		seg_th[0] = t1;
		seg_th[1] = t2;
		seg_th[2] = t3;
		write_reg(CFG_AWAKE_TH, t1);
		write_reg(CFG_RELAX_TH, t2);
		write_reg(CFG_DEEP_TH, t3);
		write_reg(CFG_LED_RES, 16'(res));
	endtask

	task automatic wait_idle(int settle);
		do @(negedge clk);
		while (pending_words.size() != 0 || sensor_ch.valid || expected_fades.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		bit [TIME_BITS-1:0]   t;
		bit [ENERGY_BITS-1:0] tq[$];
		bit [RES_BITS-1:0]    res;
		errors    = 0;
		idle_mode = 0;
		arst_n    = 1'b0;
		sensor_ch.valid              = 1'b0;
		sensor_ch.auto_mode          = 1'b0;
		sensor_ch.brightness_percent = '0;
		sensor_ch.movement           = 1'b0;
		sensor_ch.presence           = 1'b0;
		sensor_ch.energy_level       = '0;
		sensor_ch.now_ms             = '0;
		fade_ch.ready                = 1'b0;
		cfg_ch.valid                 = 1'b0;
		cfg_ch.index                 = CFG_AWAKE_TH;
		cfg_ch.data                  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero thresholds, 8-bit drive
		push_word(1'b0, 8'd50, 1'b0, 1'b0, 16'h1234, 32'd123);
		push_word(1'b1, 8'd255, 1'b1, 1'b1, 16'hFFFF, 32'd200);
		push_word(1'b1, 8'd100, 1'b0, 1'b0, 16'h0000, 32'd300);
		wait_idle(8);

		write_config(16'd40000, 16'd20000, 16'd5000, 5'd12);
		t = 32'hFFFF_FF00;
		push_word(1'b1, 8'd100, 1'b0, 1'b1, 16'd0, t);
		push_word(1'b1, 8'd77, 1'b1, 1'b1, 16'd40001, t + 5);
		push_word(1'b1, 8'd60, 1'b0, 1'b1, 16'd40000, t + 5 + AWAKE_HOLD_MS);
		t = t + 5 + AWAKE_HOLD_MS + 1;
		push_word(1'b1, 8'd60, 1'b0, 1'b1, 16'd40000, t);
		push_word(1'b1, 8'd101, 1'b0, 1'b1, 16'd20000, t + RELAX_HOLD_MS);
		t = t + RELAX_HOLD_MS + 1;
		push_word(1'b1, 8'd101, 1'b0, 1'b1, 16'd20000, t);
		push_word(1'b1, 8'd90, 1'b0, 1'b1, 16'd5001, t + 1);
		t = t + 2;
		push_word(1'b1, 8'd90, 1'b1, 1'b1, 16'd20001, t);
		t = t + RELAX_HOLD_MS + 1;
		push_word(1'b1, 8'd90, 1'b0, 1'b1, 16'd20000, t);
		t = t + 1;
		push_word(1'b1, 8'd90, 1'b0, 1'b1, 16'd5000, t);
		push_word(1'b1, 8'd90, 1'b1, 1'b0, 16'd5000, t + 1);
		t = t + 2;
		push_word(1'b1, 8'd0, 1'b1, 1'b1, 16'd5001, t);
		push_word(1'b1, 8'd80, 1'b0, 1'b1, 16'd20000, t + WAKE_HOLD_MS);
		t = t + WAKE_HOLD_MS + 1;
		push_word(1'b1, 8'd80, 1'b0, 1'b1, 16'd20000, t);
		t = t + 1;
		push_word(1'b1, 8'd80, 1'b1, 1'b1, 16'd40001, t);
		push_word(1'b1, 8'd80, 1'b1, 1'b1, 16'd0, 32'hFFFF_FFFF);
		push_word(1'b0, 8'd80, 1'b1, 1'b1, 16'hFFFF, 32'd0);
		push_word(1'b1, 8'd80, 1'b1, 1'b0, 16'hFFFF, 32'd5);
		push_word(1'b1, 8'd80, 1'b0, 1'b0, 16'hFFFF, 32'd10);
		wait_idle(8);

		for (int seg = 1; seg <= NUM_SEGS; seg++) begin
			idle_mode = (seg - 1) / 3;
			tq = '{16'($urandom), 16'($urandom), 16'($urandom)};
			if (seg != 5)
				tq.rsort();
			res = RES_BITS'($urandom_range(16, 1));
			case (seg)
				1: begin
					tq  = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
					res = 5'd16;
				end
				2: begin
					tq  = '{16'h0000, 16'h0000, 16'h0000};
					res = 5'd1;
				end
				8: res = 5'd0;
				9: res = 5'd31;
				default: ;
			endcase
			write_config(tq[0], tq[1], tq[2], res);
			gen_now = $urandom;
			for (int i = 0; i < ITEMS_PER_SEG; i++)
				pending_words.push_back(random_word());
			wait_idle(8);
		end

		wait_idle(16);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
